/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes of the circular deque
// Request and result field widths, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int FUNC_W   = 2;
    localparam int IO_W     = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Operation codes carried by req.func
    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_REAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM_FRONT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REM_REAR  = 2'd3;

    // Status codes carried by rsp.status
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Command for one row of cells
    typedef enum logic [1:0] {
        CELL_HOLD,    // keep contents
        CELL_PUSH,    // take left neighbor, new element enters at cell 0
        CELL_POP,     // take right neighbor, cell 0 leaves
        CELL_APPEND   // cell at the tail index loads the new element
    } cell_op_t;

    typedef struct packed {
        cell_op_t op_a;   // row ordered from the front
        cell_op_t op_b;   // row ordered from the rear
    } row_cmd_t;

endpackage

/* rtl/cdq_if.sv */
// ----------------------------------------------------------------------------
// cdq_if: request and result channels of the circular deque
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::FUNC_W-1:0]          func;
    logic signed [cdq_pkg::IO_W-1:0]     data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::IO_W-1:0]     data_out;
    logic [cdq_pkg::STATUS_W-1:0]        status;
    logic [cdq_pkg::FILL_W-1:0]          fill_count;

    modport source (output valid, output data_out, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input data_out, input status, input fill_count,
                    output ready);
endinterface

/* rtl/cdq_cell.sv */
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of a deque row
// Holds one element; shifts from a neighbor or loads at the tail per command.
// ----------------------------------------------------------------------------
module cdq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  cdq_pkg::cell_op_t     op,
    input  logic [CNT_W-1:0]      held,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] elem,
    output logic [DATA_WIDTH-1:0] q
);
    import cdq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  tail_here;

    assign tail_here = (held == CNT_W'(INDEX));

    always_comb
    begin
        unique case (op)
            CELL_HOLD:   data_next = data_reg;
            CELL_PUSH:   data_next = left_data;
            CELL_POP:    data_next = right_data;
            CELL_APPEND: data_next = tail_here ? elem : data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* rtl/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl: request decode, fill count and result register
// Decides status and row commands, tracks the count, holds the result.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cdq_req_if.sink               req,
    cdq_rsp_if.source             rsp,
    input  logic [DATA_WIDTH-1:0] head_a,
    input  logic [DATA_WIDTH-1:0] head_b,
    output cdq_pkg::row_cmd_t     cmd,
    output logic [CNT_W-1:0]      held,
    output logic [DATA_WIDTH-1:0] elem
);
    import cdq_pkg::*;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [CNT_W-1:0]      held_reg;
    logic [CNT_W-1:0]      held_next;
    logic [STATUS_W-1:0]   stat;
    logic [DATA_WIDTH-1:0] taken;
    row_cmd_t              cmd_raw;

    logic                  out_valid_reg;
    logic [IO_W-1:0]       data_out_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [FILL_W-1:0]     fill_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (held_reg == CNT_W'(DEPTH));
    assign empty     = (held_reg == '0);
    assign elem      = DATA_WIDTH'($unsigned(req.data_in));

    always_comb
    begin
        cmd_raw.op_a = CELL_HOLD;
        cmd_raw.op_b = CELL_HOLD;
        held_next    = held_reg;
        stat         = STAT_DONE;
        taken        = '0;
        unique case (req.func)
            FUNC_INS_FRONT, FUNC_INS_REAR:
            begin
                if (full)
                begin
                    stat = STAT_FULL;
                end
                else
                begin
                    held_next = held_reg + CNT_W'(1);
                    if (req.func == FUNC_INS_FRONT)
                    begin
                        cmd_raw.op_a = CELL_PUSH;
                        cmd_raw.op_b = CELL_APPEND;
                    end
                    else
                    begin
                        cmd_raw.op_a = CELL_APPEND;
                        cmd_raw.op_b = CELL_PUSH;
                    end
                end
            end
            FUNC_REM_FRONT, FUNC_REM_REAR:
            begin
                if (empty)
                begin
                    stat = STAT_EMPTY;
                end
                else
                begin
                    // dropping the far end of the other row needs no write
                    held_next = held_reg - CNT_W'(1);
                    if (req.func == FUNC_REM_FRONT)
                    begin
                        taken        = head_a;
                        cmd_raw.op_a = CELL_POP;
                    end
                    else
                    begin
                        taken        = head_b;
                        cmd_raw.op_b = CELL_POP;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        cmd = cmd_raw;
        if (!accept)
        begin
            cmd.op_a = CELL_HOLD;
            cmd.op_b = CELL_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg <= held_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg <= IO_W'(taken);
            status_reg   <= stat;
            fill_reg     <= FILL_W'(held_next);
        end
    end

    assign held           = held_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = data_out_reg;
    assign rsp.status     = status_reg;
    assign rsp.fill_count = fill_reg;

endmodule

/* rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque: fixed-capacity double-ended queue
// Two rows of shifting cells give both ends of the queue at a fixed place.
// ----------------------------------------------------------------------------
// The deque holds up to DEPTH elements of DATA_WIDTH bits and takes one
// request per clock while results are taken: insert front, insert rear,
// remove front or remove rear. Every request yields exactly one result in
// the next cycle, carrying the status (done, full, empty), the fill count
// after the request (low five bits), and for a successful removal the
// element taken out (zero otherwise). An insert into a full deque or a
// removal from an empty one changes nothing. A request is accepted even
// while the previous result is waiting, as long as that result is taken in
// the same cycle, so the throughput is one request per cycle. Storage is
// two rows of DEPTH cells each: row A keeps the elements in order from the
// front, row B in order from the rear. Each end is therefore always found
// in cell 0 of one row, and the other row only loads or forgets at its
// tail, which each cell finds by comparing its own index with the
// broadcast fill count. No clearing is done after reset; unwritten cells
// are never returned.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    cdq_req_if.sink   req,
    cdq_rsp_if.source rsp
);
    import cdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    row_cmd_t              cmd;
    logic [CNT_W-1:0]      held;
    logic [DATA_WIDTH-1:0] elem;

    // Cell outputs and neighbor links of both rows
    logic [DATA_WIDTH-1:0] row_a   [DEPTH];
    logic [DATA_WIDTH-1:0] row_b   [DEPTH];
    logic [DATA_WIDTH-1:0] left_a  [DEPTH];
    logic [DATA_WIDTH-1:0] right_a [DEPTH];
    logic [DATA_WIDTH-1:0] left_b  [DEPTH];
    logic [DATA_WIDTH-1:0] right_b [DEPTH];

    // Decode requests, keep the count and hold the result
    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .head_a (row_a[0]),
        .head_b (row_b[0]),
        .cmd    (cmd),
        .held   (held),
        .elem   (elem)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        // Feed the new element into cell 0 on a push
        if (i == 0)
        begin : g_head
            assign left_a[i] = elem;
            assign left_b[i] = elem;
        end
        else
        begin : g_inner_left
            assign left_a[i] = row_a[i-1];
            assign left_b[i] = row_b[i-1];
        end

        // Hold the last cell on a pop; its old value lies beyond the tail
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_a[i] = row_a[i];
            assign right_b[i] = row_b[i];
        end
        else
        begin : g_inner_right
            assign right_a[i] = row_a[i+1];
            assign right_b[i] = row_b[i+1];
        end

        cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell_a (
            .clk        (clk),
            .op         (cmd.op_a),
            .held       (held),
            .left_data  (left_a[i]),
            .right_data (right_a[i]),
            .elem       (elem),
            .q          (row_a[i])
        );

        cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell_b (
            .clk        (clk),
            .op         (cmd.op_b),
            .held       (held),
            .left_data  (left_b[i]),
            .right_data (right_b[i]),
            .elem       (elem),
            .q          (row_b[i])
        );
    end

    // The count never passes the capacity
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held <= CNT_W'(DEPTH))
        else $error("deque fill count above capacity");

    // Every accepted request leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid)
        else $error("accepted request produced no result");

    // With one element held both rows show the same head
    a_single_head: assert property (@(posedge clk) disable iff (!rst_n)
        (held == CNT_W'(1)) |-> (row_a[0] == row_b[0]))
        else $error("front and rear rows disagree on a single element");

    // A refused insert reports a full deque
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_FULL) |-> (rsp.fill_count == FILL_W'(DEPTH)))
        else $error("full status with a count below capacity");

endmodule

/* bench/tb_circular_deque.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque: self-checking bench for the circular deque
// Drives insert/remove requests with random gaps on both channels, predicts
// every result with a behavioral deque and compares field by field.
// ----------------------------------------------------------------------------
module tb_circular_deque;
    import cdq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 875;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PRINT_LIMIT    = 40;

    // One expected result of the deque
    typedef struct {
        logic signed [IO_W-1:0]  data_out;
        logic [STATUS_W-1:0]     status;
        logic [FILL_W-1:0]       fill_count;
    } deque_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own deque, turns each accepted request into the
    // result the block must return and checks returned results in order.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] slots [DEPTH];
        int unsigned           front_pos;
        int unsigned           rear_pos;
        int unsigned           held;
        deque_result_t         expected_q [$];
        int unsigned           errors;
        int unsigned           checked;
        int unsigned           refused_full;
        int unsigned           refused_empty;
        int unsigned           peak_fill;
        int unsigned           op_count [4];

        task report_mismatch(string what, logic [IO_W-1:0] got, logic [IO_W-1:0] want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch on %s: got %0h, expected %0h",
                         $realtime, what, got, want);
        endtask

        // Apply one accepted request to the shadow deque and queue its result
        function void note_request(logic [FUNC_W-1:0] func, logic [IO_W-1:0] data_in);
            deque_result_t res;
            res.data_out = '0;
            res.status   = STAT_DONE;
            op_count[func]++;
            case (func)
                FUNC_INS_FRONT, FUNC_INS_REAR:
                begin
                    if (held >= DEPTH)
                    begin
                        res.status = STAT_FULL;
                        refused_full++;
                    end
                    else if (held == 0)
                    begin
                        // first element always lands at position zero
                        front_pos = 0;
                        rear_pos  = 0;
                        slots[0]  = data_in[DATA_WIDTH-1:0];
                        held      = 1;
                    end
                    else if (func == FUNC_INS_FRONT)
                    begin
                        front_pos = (front_pos == 0) ? DEPTH - 1 : front_pos - 1;
                        slots[front_pos] = data_in[DATA_WIDTH-1:0];
                        held++;
                    end
                    else
                    begin
                        rear_pos = (rear_pos + 1 >= DEPTH) ? 0 : rear_pos + 1;
                        slots[rear_pos] = data_in[DATA_WIDTH-1:0];
                        held++;
                    end
                end
                default:
                begin
                    if (held == 0)
                    begin
                        res.status = STAT_EMPTY;
                        refused_empty++;
                    end
                    else
                    begin
                        if (func == FUNC_REM_FRONT)
                        begin
                            res.data_out = slots[front_pos];
                            front_pos = (front_pos + 1 >= DEPTH) ? 0 : front_pos + 1;
                        end
                        else
                        begin
                            res.data_out = slots[rear_pos];
                            rear_pos = (rear_pos == 0) ? DEPTH - 1 : rear_pos - 1;
                        end
                        held--;
                        if (held == 0)
                        begin
                            front_pos = 0;
                            rear_pos  = 0;
                        end
                    end
                end
            endcase
            if (held > peak_fill)
                peak_fill = held;
            res.fill_count = held[FILL_W-1:0];
            expected_q.push_back(res);
        endfunction

        // Compare one returned result with the oldest expectation
        task check_result(logic signed [IO_W-1:0] data_out, logic [STATUS_W-1:0] status,
                          logic [FILL_W-1:0] fill_count);
            deque_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", data_out, '0);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (data_out !== want.data_out)
                report_mismatch("data_out", data_out, want.data_out);
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (fill_count !== want.fill_count)
                report_mismatch("fill_count", fill_count, want.fill_count);
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    cdq_req_if        req_ch ();
    cdq_rsp_if        rsp_ch ();
    deque_scoreboard  sb;
    int unsigned      tx_idle_pct;
    int unsigned      rx_idle_pct;
    logic             holdoff_req;
    int unsigned      hold_left;
    int unsigned      cycle_count;

    circular_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: drop ready at random, or hold it low for a long stretch
    // when a hold-off is requested so that the block backs up into its input.
    always @(negedge clk)
    begin
        if (holdoff_req)
        begin
            hold_left   = HOLDOFF_CYCLES;
            holdoff_req = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Sample results on the rising edge and check them
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.data_out, rsp_ch.status, rsp_ch.fill_count);
    end

    // Offer one request, with random idle cycles ahead of it; return at the
    // falling edge after the handshake so the next call can keep valid high.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [IO_W-1:0] data_in);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= func;
        req_ch.data_in <= data_in;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(func, data_in);
        @(negedge clk);
    endtask

    // Mostly random words, with the sign and all-ones/all-zeros corners mixed in
    function automatic logic [IO_W-1:0] pick_element();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int unsigned  sent;
        int unsigned  burst_left;
        int unsigned  ins_bias;
        logic [FUNC_W-1:0] func;

        sb             = new;
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_INS_FRONT;
        req_ch.data_in = '0;
        rsp_ch.ready   = 1'b0;
        holdoff_req    = 1'b0;
        hold_left      = 0;
        cycle_count    = 0;
        tx_idle_pct    = 13;
        rx_idle_pct    = 86;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: removals from an empty deque, single-element round trips
        // through both ends, a fill to capacity, refused inserts at both ends.
        send_request(FUNC_REM_FRONT, 32'h1234_5678);
        send_request(FUNC_REM_REAR,  32'hdead_beef);
        send_request(FUNC_INS_FRONT, 32'h8000_0000);
        send_request(FUNC_REM_REAR,  32'h0);
        send_request(FUNC_INS_REAR,  32'h7fff_ffff);
        send_request(FUNC_REM_FRONT, 32'hffff_ffff);
        for (int i = 0; i < DEPTH; i++)
            send_request(i[0] ? FUNC_INS_REAR : FUNC_INS_FRONT,
                         (i < 4) ? pick_element() : $urandom());
        send_request(FUNC_INS_FRONT, 32'h5a5a_5a5a);
        send_request(FUNC_INS_REAR,  32'ha5a5_a5a5);
        send_request(FUNC_REM_FRONT, 32'h0);

        // Random: bursts that lean toward filling, toward draining, or neither,
        // so the deque keeps crossing both the full and the empty boundary.
        sent       = 0;
        burst_left = 0;
        ins_bias   = 50;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 86;
                rx_idle_pct = 13;
            end
            else if (sent == 2 * RANDOM_ITEMS / 3)
            begin
                // no idling from here; stall the result side once for a while
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                holdoff_req = 1'b1;
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(8, 40);
                case ($urandom_range(2))
                    0:       ins_bias = 85;
                    1:       ins_bias = 15;
                    default: ins_bias = 50;
                endcase
            end
            if ($urandom_range(99) < ins_bias)
                func = $urandom_range(1) ? FUNC_INS_REAR : FUNC_INS_FRONT;
            else
                func = $urandom_range(1) ? FUNC_REM_REAR : FUNC_REM_FRONT;
            send_request(func, pick_element());
            burst_left--;
            sent++;
        end
        req_ch.valid <= 1'b0;

        // Wait for every owed result, then watch a little longer for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d insert front, %0d insert rear, %0d remove front, %0d remove rear",
                 sb.op_count[FUNC_INS_FRONT], sb.op_count[FUNC_INS_REAR],
                 sb.op_count[FUNC_REM_FRONT], sb.op_count[FUNC_REM_REAR]);
        $display("results checked %0d; refused full %0d, refused empty %0d; peak fill %0d",
                 sb.checked, sb.refused_full, sb.refused_empty, sb.peak_fill);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
